/* rtl/core/pia_pkg.sv */
// Shared types, widths and codes for the pixelwise image ALU.
// No dependencies; every other file in rtl/core imports this package.
`default_nettype none
package pia_pkg;

   // Pixel format: signed fixed point, FRAC_W fraction bits in PIX_W bits
   localparam int PIX_W  = 32;
   localparam int FRAC_W = 16;

   // Square root of (b << FRAC_W): ROOT_W result bits, two radicand bits per step
   localparam int ROOT_W = (PIX_W + FRAC_W + 1) / 2;
   localparam int RAD_W  = 2 * ROOT_W;
   // Quotient of (magnitude << FRAC_W) over divisor: one quotient bit per step
   localparam int NUM_W  = PIX_W + FRAC_W;
   localparam int DEN_W  = (ROOT_W > PIX_W) ? ROOT_W : PIX_W;
   // Width of the value handed to saturation (product >> FRAC_W or quotient)
   localparam int PROD_W = 2 * PIX_W;
   localparam int QW     = ((PROD_W - FRAC_W) > NUM_W) ? (PROD_W - FRAC_W) : NUM_W;

   // start accepted -> rsp_valid: input reg, front, sqrt, divide, two back stages
   localparam int LATENCY = 4 + ROOT_W + NUM_W;

   localparam logic [PIX_W-1:0] PIX_MAX = {1'b0, {(PIX_W-1){1'b1}}};
   localparam logic [PIX_W-1:0] PIX_MIN = {1'b1, {(PIX_W-1){1'b0}}};

   typedef enum logic [3:0] {
      OP_ADD     = 4'd0,
      OP_SUB     = 4'd1,
      OP_MUL     = 4'd2,
      OP_DIV     = 4'd3,
      OP_OR      = 4'd4,
      OP_XOR     = 4'd5,
      OP_AND     = 4'd6,
      OP_MAX     = 4'd7,
      OP_REPLACE = 4'd8,
      OP_GT      = 4'd9,
      OP_LT      = 4'd10,
      OP_MIN     = 4'd11,
      OP_ZSCORE  = 4'd12
   } op_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_OVF  = 2'd1,
      ST_DIVZ = 2'd2,
      ST_VAR  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      KIND_SIMPLE,
      KIND_MUL,
      KIND_QUOT
   } kind_type;

   typedef struct packed {
      logic signed [PIX_W-1:0] pixel_a;
      logic signed [PIX_W-1:0] pixel_b;
      logic signed [PIX_W-1:0] pixel_c;
   } req_type;

   typedef struct packed {
      logic signed [PIX_W-1:0] result_pixel;
      logic [1:0]              status;
   } rsp_type;

   // What the back end needs to finish a transaction
   typedef struct packed {
      kind_type         kind;
      logic             neg;
      logic [PIX_W-1:0] res;
      status_type       st;
      logic [PIX_W-1:0] mag_a;
      logic [PIX_W-1:0] mag_b;
   } side_type;

   typedef struct packed {
      side_type          side;
      logic [NUM_W-1:0]  num;
      logic [PIX_W-1:0]  den;
      logic              is_zs;
      logic [RAD_W-1:0]  rad;
      logic [ROOT_W-1:0] root;
      logic [ROOT_W+1:0] rem;
   } sq_type;

   typedef struct packed {
      side_type         side;
      logic [NUM_W-1:0] nq;
      logic [DEN_W-1:0] den;
      logic [DEN_W-1:0] rem;
   } dv_type;

endpackage
`default_nettype wire

/* rtl/core/pia_front.sv */
// Front stage: simple operations, operand magnitudes and special cases.
// Depends on pia_pkg.
`default_nettype none
module pia_front
   import pia_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_vld,
   input  wire req_type in_req,
   input  wire op_type  op,
   output logic         out_vld,
   output sq_type       out_sq
);

   logic              vld_ff;
   sq_type            sq_ff;
   sq_type            sq_in;
   logic signed [PIX_W-1:0] a, b, c;
   logic signed [PIX_W:0]   sum, dif, zd;
   logic [PIX_W-1:0]  mag_a, mag_b, mag_d, one;
   logic              na, nb;

   always_comb begin
      a     = in_req.pixel_a;
      b     = in_req.pixel_b;
      c     = in_req.pixel_c;
      one   = PIX_W'(1) << FRAC_W;
      na    = (a != '0);
      nb    = (b != '0);
      sum   = (PIX_W+1)'(a) + (PIX_W+1)'(b);
      dif   = (PIX_W+1)'(a) - (PIX_W+1)'(b);
      zd    = (PIX_W+1)'(c) - (PIX_W+1)'(a);
      mag_a = a[PIX_W-1] ? PIX_W'(-a) : PIX_W'(a);
      mag_b = b[PIX_W-1] ? PIX_W'(-b) : PIX_W'(b);
      mag_d = zd[PIX_W] ? PIX_W'(-zd) : PIX_W'(zd);

      sq_in            = '0;
      sq_in.side.kind  = KIND_SIMPLE;
      sq_in.side.st    = ST_OK;
      sq_in.side.mag_a = mag_a;
      sq_in.side.mag_b = mag_b;
      sq_in.rad        = RAD_W'({b, {FRAC_W{1'b0}}});

      case (op)
         OP_ADD: begin
            if (sum[PIX_W] != sum[PIX_W-1]) begin
               sq_in.side.st  = ST_OVF;
               sq_in.side.res = sum[PIX_W] ? PIX_MIN : PIX_MAX;
            end else begin
               sq_in.side.res = sum[PIX_W-1:0];
            end
         end
         OP_SUB: begin
            if (dif[PIX_W] != dif[PIX_W-1]) begin
               sq_in.side.st  = ST_OVF;
               sq_in.side.res = dif[PIX_W] ? PIX_MIN : PIX_MAX;
            end else begin
               sq_in.side.res = dif[PIX_W-1:0];
            end
         end
         OP_MUL: begin
            sq_in.side.kind = KIND_MUL;
            sq_in.side.neg  = a[PIX_W-1] ^ b[PIX_W-1];
         end
         OP_DIV: begin
            if (!nb) begin
               sq_in.side.st  = ST_DIVZ;
               sq_in.side.res = !na ? '0 : (a[PIX_W-1] ? PIX_MIN : PIX_MAX);
            end else begin
               sq_in.side.kind = KIND_QUOT;
               sq_in.side.neg  = a[PIX_W-1] ^ b[PIX_W-1];
               sq_in.num       = {mag_a, {FRAC_W{1'b0}}};
               sq_in.den       = mag_b;
            end
         end
         OP_OR:      sq_in.side.res = (na || nb) ? one : '0;
         OP_XOR:     sq_in.side.res = (na != nb) ? one : '0;
         OP_AND:     sq_in.side.res = (na && nb) ? one : '0;
         OP_MAX:     sq_in.side.res = (a < b) ? b : a;
         OP_REPLACE: sq_in.side.res = nb ? b : a;
         OP_GT:      sq_in.side.res = (b < a) ? one : '0;
         OP_LT:      sq_in.side.res = (a < b) ? one : '0;
         OP_MIN:     sq_in.side.res = (b < a) ? b : a;
         OP_ZSCORE: begin
            if (!nb || b[PIX_W-1]) begin
               sq_in.side.st = ST_VAR;
            end else begin
               sq_in.side.kind = KIND_QUOT;
               sq_in.side.neg  = zd[PIX_W];
               sq_in.num       = {mag_d, {FRAC_W{1'b0}}};
               sq_in.is_zs     = 1'b1;
            end
         end
         default: sq_in.side.res = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= in_vld;
      end
      sq_ff <= sq_in;
   end

   assign out_vld = vld_ff;
   assign out_sq  = sq_ff;

endmodule
`default_nettype wire

/* rtl/core/pia_sqrt.sv */
// Pipelined integer square root, two radicand bits per stage.
// Depends on pia_pkg.
`default_nettype none
module pia_sqrt
   import pia_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   in_vld,
   input  wire sq_type in_sq,
   output logic        out_vld,
   output sq_type      out_sq
);

   function automatic sq_type sqrt_step(sq_type s);
      sq_type            o;
      logic [ROOT_W+3:0] rn;
      logic [ROOT_W+3:0] tr;
      o     = s;
      rn    = {s.rem, s.rad[RAD_W-1 -: 2]};
      tr    = (ROOT_W+4)'({s.root, 2'b01});
      o.rad = s.rad << 2;
      if (rn >= tr) begin
         o.rem  = (ROOT_W+2)'(rn - tr);
         o.root = {s.root[ROOT_W-2:0], 1'b1};
      end else begin
         o.rem  = (ROOT_W+2)'(rn);
         o.root = {s.root[ROOT_W-2:0], 1'b0};
      end
      return o;
   endfunction

   logic   vld_ff [ROOT_W];
   sq_type stg_ff [ROOT_W];

   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      logic   vld_in;
      sq_type stg_in;
      if (k == 0) begin : g_head
         always_comb begin
            vld_in = in_vld;
            stg_in = sqrt_step(in_sq);
         end
      end else begin : g_tail
         always_comb begin
            vld_in = vld_ff[k-1];
            stg_in = sqrt_step(stg_ff[k-1]);
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_in;
         end
         stg_ff[k] <= stg_in;
      end
   end

   assign out_vld = vld_ff[ROOT_W-1];
   assign out_sq  = stg_ff[ROOT_W-1];

endmodule
`default_nettype wire

/* rtl/core/pia_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
// Depends on pia_pkg; takes the divisor from the root for z-score.
`default_nettype none
module pia_div
   import pia_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   in_vld,
   input  wire sq_type in_sq,
   output logic        out_vld,
   output dv_type      out_dv
);

   function automatic dv_type div_step(dv_type s);
      dv_type         o;
      logic [DEN_W:0] rn;
      logic           q;
      o  = s;
      rn = {s.rem, s.nq[NUM_W-1]};
      q  = (rn >= {1'b0, s.den});
      if (q) begin
         o.rem = DEN_W'(rn - {1'b0, s.den});
      end else begin
         o.rem = DEN_W'(rn);
      end
      o.nq = {s.nq[NUM_W-2:0], q};
      return o;
   endfunction

   dv_type entry;
   logic   vld_ff [NUM_W];
   dv_type stg_ff [NUM_W];

   always_comb begin
      entry.side = in_sq.side;
      entry.nq   = in_sq.num;
      entry.den  = in_sq.is_zs ? DEN_W'(in_sq.root) : DEN_W'(in_sq.den);
      entry.rem  = '0;
   end

   for (genvar k = 0; k < NUM_W; k++) begin : g_stage
      logic   vld_in;
      dv_type stg_in;
      if (k == 0) begin : g_head
         always_comb begin
            vld_in = in_vld;
            stg_in = div_step(entry);
         end
      end else begin : g_tail
         always_comb begin
            vld_in = vld_ff[k-1];
            stg_in = div_step(stg_ff[k-1]);
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_in;
         end
         stg_ff[k] <= stg_in;
      end
   end

   assign out_vld = vld_ff[NUM_W-1];
   assign out_dv  = stg_ff[NUM_W-1];

endmodule
`default_nettype wire

/* rtl/core/pia_back.sv */
// Back end: magnitude multiply, then saturation, sign and result register.
// Depends on pia_pkg.
`default_nettype none
module pia_back
   import pia_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   in_vld,
   input  wire dv_type in_dv,
   output logic        out_vld,
   output rsp_type     out_rsp
);

   logic              m_vld_ff;
   side_type          m_side_ff;
   logic [NUM_W-1:0]  m_nq_ff;
   logic [PROD_W-1:0] m_prod_ff;
   logic [PROD_W-1:0] m_prod_in;

   logic              r_vld_ff;
   rsp_type           r_rsp_ff;
   rsp_type           r_rsp_in;
   logic [QW-1:0]     q;

   assign m_prod_in = PROD_W'(in_dv.side.mag_a) * PROD_W'(in_dv.side.mag_b);

   always_comb begin
      if (m_side_ff.kind == KIND_MUL) begin
         q = QW'(m_prod_ff >> FRAC_W);
      end else begin
         q = QW'(m_nq_ff);
      end
      r_rsp_in.result_pixel = m_side_ff.res;
      r_rsp_in.status       = m_side_ff.st;
      if (m_side_ff.kind != KIND_SIMPLE) begin
         r_rsp_in.status = ST_OK;
         if (m_side_ff.neg) begin
            if (q > QW'(PIX_MIN)) begin
               r_rsp_in.result_pixel = PIX_MIN;
               r_rsp_in.status       = ST_OVF;
            end else begin
               r_rsp_in.result_pixel = -q[PIX_W-1:0];
            end
         end else begin
            if (q > QW'(PIX_MAX)) begin
               r_rsp_in.result_pixel = PIX_MAX;
               r_rsp_in.status       = ST_OVF;
            end else begin
               r_rsp_in.result_pixel = q[PIX_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_vld_ff <= 1'b0;
         r_vld_ff <= 1'b0;
      end else begin
         m_vld_ff <= in_vld;
         r_vld_ff <= m_vld_ff;
      end
      m_side_ff <= in_dv.side;
      m_nq_ff   <= in_dv.nq;
      m_prod_ff <= m_prod_in;
      r_rsp_ff  <= r_rsp_in;
   end

   assign out_vld = r_vld_ff;
   assign out_rsp = r_rsp_ff;

endmodule
`default_nettype wire

/* rtl/core/pixelwise_image_alu.sv */
// Top level of the pixelwise image ALU.
// Depends on pia_pkg, pia_front, pia_sqrt, pia_div and pia_back.
//
// Usage:
//  - csr_we/csr_wdata write the 4-bit operation code (add, sub, mul, div,
//    or, xor, and, max, replace, gt, lt, min, zscore). Write it only while
//    no transaction is in flight. Reset selects add.
//  - A transaction is taken at a clock edge with start high and busy low.
//    busy is always low: one pixel triple per clock, every clock.
//  - Each result shows on rsp_data for exactly one cycle with rsp_valid
//    high, in order, in the default 32-bit Q16.16 format. The receiver
//    cannot stall.
//  - Results pass through the pipeline: input register, front stage, one
//    stage per root bit of the square root (24), one stage per quotient
//    bit of the divider (48), multiply stage and saturate/output stage.
//    Every operation takes the same path, so results never reorder.
//  - Synchronous reset clears the operation and all valid bits; items in
//    flight are dropped.
`default_nettype none
module pixelwise_image_alu
   import pia_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   // transaction input
   input  wire logic       start,
   output logic            busy,
   input  wire req_type    req_data,
   // result output
   output logic            rsp_valid,
   output rsp_type         rsp_data,
   // configuration
   input  wire logic       csr_we,
   input  wire logic [3:0] csr_wdata
);

   op_type  op_ff;
   logic    in_vld_ff;
   req_type in_req_ff;

   logic    fr_vld;
   sq_type  fr_sq;
   logic    sq_vld;
   sq_type  sq_out;
   logic    dv_vld;
   dv_type  dv_out;

   // no back-pressure anywhere in the pipe
   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff     <= OP_ADD;
         in_vld_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            op_ff <= op_type'(csr_wdata);
         end
         in_vld_ff <= start && !busy;
      end
      in_req_ff <= req_data;
   end

   // simple ops finish here; mul/div/zscore get magnitudes and signs
   pia_front u_front (
      .clock   (clock),
      .reset   (reset),
      .in_vld  (in_vld_ff),
      .in_req  (in_req_ff),
      .op      (op_ff),
      .out_vld (fr_vld),
      .out_sq  (fr_sq)
   );

   // sqrt of variance << FRAC_W, only meaningful for zscore
   pia_sqrt u_sqrt (
      .clock   (clock),
      .reset   (reset),
      .in_vld  (fr_vld),
      .in_sq   (fr_sq),
      .out_vld (sq_vld),
      .out_sq  (sq_out)
   );

   // shared divider: |a| / |b| for div, |c - a| / root for zscore
   pia_div u_div (
      .clock   (clock),
      .reset   (reset),
      .in_vld  (sq_vld),
      .in_sq   (sq_out),
      .out_vld (dv_vld),
      .out_dv  (dv_out)
   );

   pia_back u_back (
      .clock   (clock),
      .reset   (reset),
      .in_vld  (dv_vld),
      .in_dv   (dv_out),
      .out_vld (rsp_valid),
      .out_rsp (rsp_data)
   );

`ifndef SYNTHESIS
   a_fixed_latency : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("accepted transaction did not produce a result on time");

   a_no_spurious : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result without a matching transaction");

   a_var_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == ST_VAR) |-> (rsp_data.result_pixel == '0))
      else $error("variance fault with nonzero result");

   a_divz_value : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == ST_DIVZ) |->
         (rsp_data.result_pixel == '0 || rsp_data.result_pixel == PIX_MAX ||
          rsp_data.result_pixel == PIX_MIN))
      else $error("divide by zero result not saturated");
`endif

endmodule
`default_nettype wire
